// ----- src/cti_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cti_pkg
// Shared types and corner indexes for the interpolating CMYK to RGB converter.
// ----------------------------------------------------------------------------
package cti_pkg;

  localparam int CORNERS = 8;

  // corner order of the weight vectors
  localparam logic [2:0] CRN_WHITE   = 3'd0;
  localparam logic [2:0] CRN_YELLOW  = 3'd1;
  localparam logic [2:0] CRN_MAGENTA = 3'd2;
  localparam logic [2:0] CRN_MY      = 3'd3;
  localparam logic [2:0] CRN_CYAN    = 3'd4;
  localparam logic [2:0] CRN_CY      = 3'd5;
  localparam logic [2:0] CRN_CM      = 3'd6;
  localparam logic [2:0] CRN_CMY     = 3'd7;

  typedef struct packed {
    logic [7:0] cyan;
    logic [7:0] magenta;
    logic [7:0] yellow;
    logic [7:0] black;
  } cmyk_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  // corner weights of the c, m, y cube, plus scaled black
  typedef struct packed {
    logic                      is_white;
    logic                      is_black;
    logic [8:0]                k;
    logic [CORNERS-1:0][23:0]  w;
  } weight_t;

  // each corner weight but the full-ink one split by black into a lit and a dark part
  typedef struct packed {
    logic                      is_white;
    logic                      is_black;
    logic [CORNERS-2:0][23:0]  hi;
    logic [CORNERS-1:0][31:0]  lo;
  } split_t;

endpackage
`default_nettype wire

// ----- src/cti_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmyk_if / rgb_if
// Valid/ready channels for CMYK input pixels and RGB output pixels.
// ----------------------------------------------------------------------------
interface cmyk_if;
  logic       valid;
  logic       ready;
  logic [7:0] cyan;
  logic [7:0] magenta;
  logic [7:0] yellow;
  logic [7:0] black;

  modport source (output valid, output cyan, output magenta, output yellow,
                  output black, input ready);
  modport sink (input valid, input cyan, input magenta, input yellow,
                input black, output ready);
endinterface

interface rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue,
                  input ready);
  modport sink (input valid, input red, input green, input blue,
                output ready);
endinterface
`default_nettype wire

// ----- src/cti_weights.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cti_weights
// Three stages: channel scaling, c/m face weights, then the eight cube
// corner weights.
// ----------------------------------------------------------------------------
module cti_weights
  import cti_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire cmyk_t   in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output weight_t      out_data
);

  logic v1, v2, v3;
  logic adv1, adv2, adv3;

  // stage 1: scaled channels
  logic [8:0] c1, m1, k1;
  logic [7:0] y1;
  logic       white1, black1;

  // stage 2: face weights, order c1m1, c1m, cm1, cm
  logic [3:0][16:0] f2;
  logic [7:0]       y2;
  logic [8:0]       k2;
  logic             white2, black2;

  weight_t s3;

  logic [8:0]       ye;
  logic [17:0]      cm_full, c1m_full, cm1_full, c1m1_full;
  logic [3:0][16:0] f2_next;
  logic [7:0][23:0] w_next;
  logic [23:0]      wy;

  assign adv3     = !v3 || out_ready;
  assign adv2     = !v2 || adv3;
  assign adv1     = !v1 || adv2;
  assign in_ready = adv1;

  assign ye = 9'(in_data.yellow) + 9'(in_data.yellow[7]);

  always_comb begin
    cm_full   = 18'(c1) * 18'(m1);
    c1m_full  = 18'({m1, 8'd0}) - cm_full;
    cm1_full  = 18'({c1, 8'd0}) - cm_full;
    c1m1_full = 18'({9'(9'd256 - m1), 8'd0}) - cm1_full;
    f2_next[0] = c1m1_full[16:0];
    f2_next[1] = c1m_full[16:0];
    f2_next[2] = cm1_full[16:0];
    f2_next[3] = cm_full[16:0];
  end

  // each face weight gives the corner without and with yellow
  always_comb begin
    wy = '0;
    for (int j = 0; j < 4; j++) begin
      wy = 24'(f2[j]) * 24'(y2);
      w_next[2*j]   = 24'({f2[j], 7'd0}) - wy;
      w_next[2*j+1] = wy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (adv1) v1 <= in_valid;
      if (adv2) v2 <= v1;
      if (adv3) v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      c1     <= 9'(in_data.cyan) + 9'(in_data.cyan[7]);
      m1     <= 9'(in_data.magenta) + 9'(in_data.magenta[7]);
      k1     <= 9'(in_data.black) + 9'(in_data.black[7]);
      y1     <= ye[8:1];
      white1 <= (in_data.cyan == 8'd0) && (in_data.magenta == 8'd0) &&
                (in_data.yellow == 8'd0) && (in_data.black == 8'd0);
      black1 <= (in_data.black == 8'hFF);
    end
    if (adv2) begin
      f2     <= f2_next;
      y2     <= y1;
      k2     <= k1;
      white2 <= white1;
      black2 <= black1;
    end
    if (adv3) begin
      s3.w        <= w_next;
      s3.k        <= k2;
      s3.is_white <= white2;
      s3.is_black <= black2;
    end
  end

  assign out_valid = v3;
  assign out_data  = s3;

endmodule
`default_nettype wire

// ----- src/cti_corners.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cti_corners
// One stage that splits every corner weight but the full-ink one by the black
// amount, giving fifteen of the sixteen corners of the four-dimensional cube.
// ----------------------------------------------------------------------------
module cti_corners
  import cti_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire weight_t in_data,
  output logic         out_valid,
  input  wire logic    out_ready,
  output split_t       out_data
);

  logic   v4;
  split_t s4, s4_next;
  logic [31:0] hk;

  assign in_ready = !v4 || out_ready;

  always_comb begin
    hk = '0;
    s4_next.is_white = in_data.is_white;
    s4_next.is_black = in_data.is_black;
    for (int i = 0; i < CORNERS - 1; i++) begin
      hk = 32'(in_data.w[i]) * 32'(in_data.k);
      s4_next.hi[i] = hk[31:8];
      s4_next.lo[i] = {in_data.w[i], 8'd0} - hk;
    end
    // the full-ink corner only needs its lit part
    s4_next.lo[CRN_CMY] = 32'(in_data.w[CRN_CMY]) * 32'(9'(9'd256 - in_data.k));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (in_ready) begin
      v4 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) s4 <= s4_next;
  end

  assign out_valid = v4;
  assign out_data  = s4;

endmodule
`default_nettype wire

// ----- src/cti_mix.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cti_mix
// Four stages: corner color products, partial sums, channel totals, then
// rounding correction and the white/black overrides into the output register.
// ----------------------------------------------------------------------------
module cti_mix
  import cti_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire split_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output rgb_t        out_data
);

  localparam int TERMS  = 12;
  localparam int GROUPS = TERMS / 4;
  localparam logic [1:0] CH_R = 2'd0;
  localparam logic [1:0] CH_G = 2'd1;
  localparam logic [1:0] CH_B = 2'd2;

  logic v5, v6, v7, v8;
  logic adv5, adv6, adv7, adv8;

  logic [2:0][TERMS-1:0][31:0]  terms5, terms_next;
  logic [2:0][GROUPS-1:0][31:0] grp6, grp_next;
  logic [2:0][31:0]             sum7, sum_next;
  logic [2:0]                   white_p, black_p;
  rgb_t                         s8;

  logic [CORNERS-1:0][31:0] ls;
  logic [CORNERS-2:0][31:0] hs;
  logic [2:0][31:0]         corr;

  assign adv8     = !v8 || out_ready;
  assign adv7     = !v7 || adv8;
  assign adv6     = !v6 || adv7;
  assign adv5     = !v5 || adv6;
  assign in_ready = adv5;

  always_comb begin
    for (int i = 0; i < CORNERS; i++) ls[i] = in_data.lo[i] >> 8;
    for (int i = 0; i < CORNERS - 1; i++) hs[i] = 32'(in_data.hi[i]);
    terms_next = '0;
    // red
    terms_next[CH_R][0]  = in_data.lo[CRN_WHITE];
    terms_next[CH_R][1]  = 32'd35 * hs[CRN_WHITE];
    terms_next[CH_R][2]  = 32'd28 * hs[CRN_YELLOW];
    terms_next[CH_R][3]  = in_data.lo[CRN_YELLOW];
    terms_next[CH_R][4]  = 32'd36 * hs[CRN_MAGENTA];
    terms_next[CH_R][5]  = 32'd237 * ls[CRN_MAGENTA];
    terms_next[CH_R][6]  = 32'd34 * hs[CRN_MY];
    terms_next[CH_R][7]  = 32'd238 * ls[CRN_MY];
    terms_next[CH_R][8]  = 32'd46 * ls[CRN_CM];
    terms_next[CH_R][9]  = 32'd54 * ls[CRN_CMY];
    // green
    terms_next[CH_G][0]  = in_data.lo[CRN_WHITE];
    terms_next[CH_G][1]  = 32'd31 * hs[CRN_WHITE];
    terms_next[CH_G][2]  = 32'd26 * hs[CRN_YELLOW];
    terms_next[CH_G][3]  = 32'd243 * ls[CRN_YELLOW];
    terms_next[CH_G][4]  = 32'd28 * ls[CRN_MY];
    terms_next[CH_G][5]  = 32'd15 * hs[CRN_CYAN];
    terms_next[CH_G][6]  = 32'd174 * ls[CRN_CYAN];
    terms_next[CH_G][7]  = 32'd19 * hs[CRN_CY];
    terms_next[CH_G][8]  = 32'd167 * ls[CRN_CY];
    terms_next[CH_G][9]  = 32'd49 * ls[CRN_CM];
    terms_next[CH_G][10] = 32'd54 * ls[CRN_CMY];
    // blue
    terms_next[CH_B][0]  = in_data.lo[CRN_WHITE];
    terms_next[CH_B][1]  = 32'd32 * hs[CRN_WHITE];
    terms_next[CH_B][2]  = 32'd141 * ls[CRN_MAGENTA];
    terms_next[CH_B][3]  = 32'd36 * ls[CRN_MY];
    terms_next[CH_B][4]  = 32'd36 * hs[CRN_CYAN];
    terms_next[CH_B][5]  = 32'd240 * ls[CRN_CYAN];
    terms_next[CH_B][6]  = 32'd80 * ls[CRN_CY];
    terms_next[CH_B][7]  = 32'd2 * hs[CRN_CM];
    terms_next[CH_B][8]  = 32'd147 * ls[CRN_CM];
    terms_next[CH_B][9]  = 32'd57 * ls[CRN_CMY];
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int g = 0; g < GROUPS; g++) begin
        grp_next[ch][g] = terms5[ch][4*g] + terms5[ch][4*g+1] +
                          terms5[ch][4*g+2] + terms5[ch][4*g+3];
      end
      sum_next[ch] = grp6[ch][0] + grp6[ch][1] + grp6[ch][2];
      corr[ch]     = sum7[ch] - (sum7[ch] >> 8);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
    end else begin
      if (adv5) v5 <= in_valid;
      if (adv6) v6 <= v5;
      if (adv7) v7 <= v6;
      if (adv8) v8 <= v7;
    end
  end

  // override flags ride along, one bit per stage
  always_ff @(posedge clk) begin
    if (adv5) begin
      terms5     <= terms_next;
      white_p[0] <= in_data.is_white;
      black_p[0] <= in_data.is_black;
    end
    if (adv6) begin
      grp6       <= grp_next;
      white_p[1] <= white_p[0];
      black_p[1] <= black_p[0];
    end
    if (adv7) begin
      sum7       <= sum_next;
      white_p[2] <= white_p[1];
      black_p[2] <= black_p[1];
    end
    if (adv8) begin
      if (white_p[2]) begin
        s8 <= '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};
      end else if (black_p[2]) begin
        s8 <= '{red: 8'h00, green: 8'h00, blue: 8'h00};
      end else begin
        s8.red   <= corr[CH_R][30:23];
        s8.green <= corr[CH_G][30:23];
        s8.blue  <= corr[CH_B][30:23];
      end
    end
  end

  assign out_valid = v8;
  assign out_data  = s8;

endmodule
`default_nettype wire

// ----- src/cmyk_to_rgb_interpolated.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cmyk_to_rgb_interpolated
// CMYK to RGB pixel converter by multilinear interpolation over a CMYK cube.
// ----------------------------------------------------------------------------
// Takes one CMYK pixel per beat and returns one RGB pixel per beat, in order.
// The datapath is an eight-stage pipeline (scaling, face weights, corner
// weights, black split, color products, two adder levels, correction and
// output register); it sustains one pixel per clock while the output is
// not stalled. Every stage has its own valid bit and only holds when the
// stage after it is full and stalled, so bubbles are filled and input
// keeps flowing into empty stages while a finished pixel waits at the output.
// All-zero input gives white; full black gives black.
module cmyk_to_rgb_interpolated
  import cti_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  cmyk_if.sink      cmyk,
  rgb_if.source     rgb
);

  cmyk_t   pix;
  weight_t wgt;
  split_t  spl;
  rgb_t    res;
  logic    wgt_valid, wgt_ready;
  logic    spl_valid, spl_ready;

  assign pix = '{cyan: cmyk.cyan, magenta: cmyk.magenta, yellow: cmyk.yellow,
                 black: cmyk.black};

  cti_weights u_weights (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmyk.valid),
    .in_ready  (cmyk.ready),
    .in_data   (pix),
    .out_valid (wgt_valid),
    .out_ready (wgt_ready),
    .out_data  (wgt)
  );

  cti_corners u_corners (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (wgt_valid),
    .in_ready  (wgt_ready),
    .in_data   (wgt),
    .out_valid (spl_valid),
    .out_ready (spl_ready),
    .out_data  (spl)
  );

  cti_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (spl_valid),
    .in_ready  (spl_ready),
    .in_data   (spl),
    .out_valid (rgb.valid),
    .out_ready (rgb.ready),
    .out_data  (res)
  );

  assign rgb.red   = res.red;
  assign rgb.green = res.green;
  assign rgb.blue  = res.blue;

endmodule
`default_nettype wire
